/* rtl/core/dbcc_pkg.sv */
package dbcc_pkg;

  // Widths of the transaction fields.
  localparam int FIELD_BITS  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 48;
  localparam int VIS_BITS    = 48;
  localparam int COUNT_BITS  = 16;

  // Products of two samples, and the width that holds a sum of two products.
  localparam int PROD_BITS = 2 * SAMPLE_BITS;
  localparam int EXT_BITS  = (ACC_BITS > PROD_BITS + 1) ? ACC_BITS : PROD_BITS + 1;

  // Two baselines times four polarization pairs, each with a real and an imaginary part.
  localparam int NUM_PAIRS = 8;
  localparam int NUM_ACC   = 2 * NUM_PAIRS;
  localparam int SEL_BITS  = $clog2(NUM_PAIRS);
  localparam int NUM_TERMS = 4;

  localparam logic [COUNT_BITS-1:0] NR_TIMES_RESET = COUNT_BITS'(256);
  localparam logic [SEL_BITS-1:0]   SEL_LAST       = SEL_BITS'(NUM_PAIRS - 1);

  // Partial products of one pair: station sample s times reference sample c.
  localparam int P_RR = 0;  // s.re * c.re
  localparam int P_II = 1;  // s.im * c.im
  localparam int P_IR = 2;  // s.im * c.re
  localparam int P_RI = 3;  // s.re * c.im

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;
  typedef logic signed [PROD_BITS-1:0]   prod_val_t;
  typedef logic signed [EXT_BITS-1:0]    ext_t;

  // One input transaction as it arrives on the ports.
  typedef struct packed {
    logic [FIELD_BITS-1:0] a_x_re;
    logic [FIELD_BITS-1:0] a_x_im;
    logic [FIELD_BITS-1:0] a_y_re;
    logic [FIELD_BITS-1:0] a_y_im;
    logic [FIELD_BITS-1:0] b_x_re;
    logic [FIELD_BITS-1:0] b_x_im;
    logic [FIELD_BITS-1:0] b_y_re;
    logic [FIELD_BITS-1:0] b_y_im;
    logic [FIELD_BITS-1:0] c_x_re;
    logic [FIELD_BITS-1:0] c_x_im;
    logic [FIELD_BITS-1:0] c_y_re;
    logic [FIELD_BITS-1:0] c_y_im;
  } in_item_t;

  // Registered products handed from the front end to the accumulators.
  typedef struct packed {
    logic                                             valid;
    logic                                             dump;
    logic [NUM_PAIRS-1:0][NUM_TERMS-1:0][PROD_BITS-1:0] prod;
  } prod_t;

  // A finished dump pushed into the result queue.
  typedef struct packed {
    logic                              valid;
    logic [NUM_ACC-1:0][ACC_BITS-1:0]  acc;
  } push_t;

  // Take the low SAMPLE_BITS bits of a field as a signed sample.
  function automatic samp_t sample_value(input logic [FIELD_BITS-1:0] raw);
    return samp_t'(raw[SAMPLE_BITS-1:0]);
  endfunction

  // Sign-extend an accumulator to at least the output width, then keep the low bits.
  function automatic logic [VIS_BITS-1:0] vis_value(input logic [ACC_BITS-1:0] acc);
    logic [ACC_BITS+VIS_BITS-1:0] ext;
    ext = {{VIS_BITS{acc[ACC_BITS-1]}}, acc};
    return ext[VIS_BITS-1:0];
  endfunction

endpackage

/* rtl/core/dbcc_front.sv */
module dbcc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dbcc_pkg::in_item_t                  item,
  input  logic                                cfg_we,
  input  logic [dbcc_pkg::COUNT_BITS-1:0]     cfg_wdata,
  input  logic                                take,
  output dbcc_pkg::prod_t                     prod
);

  logic [dbcc_pkg::COUNT_BITS-1:0] nr_times;
  logic [dbcc_pkg::COUNT_BITS-1:0] time_count;
  logic [dbcc_pkg::COUNT_BITS-1:0] time_count_inc;
  logic                            dump_now;
  logic                            accept;
  logic                            load;

  dbcc_pkg::samp_t s_re [2][2];
  dbcc_pkg::samp_t s_im [2][2];
  dbcc_pkg::samp_t c_re [2];
  dbcc_pkg::samp_t c_im [2];
  logic [dbcc_pkg::NUM_PAIRS-1:0][dbcc_pkg::NUM_TERMS-1:0][dbcc_pkg::PROD_BITS-1:0] prod_next;

  // The product stage is held only while the accumulators refuse it.
  assign in_stall = prod.valid && !take;
  assign accept   = in_valid && !in_stall;
  assign load     = !prod.valid || take;

  // Classify the transaction: does it close the current integration?
  assign time_count_inc = time_count + dbcc_pkg::COUNT_BITS'(1);
  assign dump_now = (time_count_inc >= nr_times) || (time_count_inc == '0);

  // Samples, indexed by station and polarization.
  always_comb begin
    s_re[0][0] = dbcc_pkg::sample_value(item.a_x_re);
    s_im[0][0] = dbcc_pkg::sample_value(item.a_x_im);
    s_re[0][1] = dbcc_pkg::sample_value(item.a_y_re);
    s_im[0][1] = dbcc_pkg::sample_value(item.a_y_im);
    s_re[1][0] = dbcc_pkg::sample_value(item.b_x_re);
    s_im[1][0] = dbcc_pkg::sample_value(item.b_x_im);
    s_re[1][1] = dbcc_pkg::sample_value(item.b_y_re);
    s_im[1][1] = dbcc_pkg::sample_value(item.b_y_im);
    c_re[0]    = dbcc_pkg::sample_value(item.c_x_re);
    c_im[0]    = dbcc_pkg::sample_value(item.c_x_im);
    c_re[1]    = dbcc_pkg::sample_value(item.c_y_re);
    c_im[1]    = dbcc_pkg::sample_value(item.c_y_im);
  end

  // Thirty-two multipliers, four for each baseline and polarization pair.
  for (genvar k = 0; k < dbcc_pkg::NUM_PAIRS; k++) begin : g_pair
    localparam int B = k / 4;
    localparam int P = (k / 2) % 2;
    localparam int Q = k % 2;
    dbcc_pkg::prod_val_t rr, ii, ir, ri;
    assign rr = s_re[B][P] * c_re[Q];
    assign ii = s_im[B][P] * c_im[Q];
    assign ir = s_im[B][P] * c_re[Q];
    assign ri = s_re[B][P] * c_im[Q];
    assign prod_next[k][dbcc_pkg::P_RR] = rr;
    assign prod_next[k][dbcc_pkg::P_II] = ii;
    assign prod_next[k][dbcc_pkg::P_IR] = ir;
    assign prod_next[k][dbcc_pkg::P_RI] = ri;
  end

  // Control: register, time counter and product stage; the payload has no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      nr_times   <= dbcc_pkg::NR_TIMES_RESET;
      time_count <= '0;
      prod.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        nr_times <= cfg_wdata;
      end
      if (accept) begin
        time_count <= dump_now ? '0 : time_count_inc;
      end
      if (load) begin
        prod.valid <= in_valid;
      end
    end
    if (accept) begin
      prod.dump <= dump_now;
      prod.prod <= prod_next;
    end
  end

endmodule

/* rtl/core/dbcc_accum.sv */
module dbcc_accum (
  input  logic            clk,
  input  logic            rst,
  input  dbcc_pkg::prod_t prod,
  input  logic            q_full,
  output logic            take,
  output dbcc_pkg::push_t push
);

  logic [dbcc_pkg::ACC_BITS-1:0] acc [dbcc_pkg::NUM_ACC];
  logic [dbcc_pkg::NUM_ACC-1:0][dbcc_pkg::ACC_BITS-1:0] sum;

  // A closing transaction waits until the result queue has room.
  assign take       = prod.valid && (!prod.dump || !q_full);
  assign push.valid = take && prod.dump;
  assign push.acc   = sum;

  // Complex multiply-accumulate with the conjugate of the reference.
  for (genvar k = 0; k < dbcc_pkg::NUM_PAIRS; k++) begin : g_mac
    dbcc_pkg::ext_t d_re, d_im;
    assign d_re = dbcc_pkg::ext_t'(dbcc_pkg::prod_val_t'(prod.prod[k][dbcc_pkg::P_RR]))
                + dbcc_pkg::ext_t'(dbcc_pkg::prod_val_t'(prod.prod[k][dbcc_pkg::P_II]));
    assign d_im = dbcc_pkg::ext_t'(dbcc_pkg::prod_val_t'(prod.prod[k][dbcc_pkg::P_IR]))
                - dbcc_pkg::ext_t'(dbcc_pkg::prod_val_t'(prod.prod[k][dbcc_pkg::P_RI]));
    assign sum[2*k]   = acc[2*k]   + d_re[dbcc_pkg::ACC_BITS-1:0];
    assign sum[2*k+1] = acc[2*k+1] + d_im[dbcc_pkg::ACC_BITS-1:0];
  end

  // Accumulators clear after their contents go to the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dbcc_pkg::NUM_ACC; i++) begin
        acc[i] <= '0;
      end
    end else if (take) begin
      for (int i = 0; i < dbcc_pkg::NUM_ACC; i++) begin
        acc[i] <= prod.dump ? '0 : sum[i];
      end
    end
  end

endmodule

/* rtl/core/dbcc_back.sv */
module dbcc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  dbcc_pkg::push_t                   push,
  output logic                              q_full,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              which_baseline,
  output logic [1:0]                        pol_product,
  output logic signed [dbcc_pkg::VIS_BITS-1:0] vis_re,
  output logic signed [dbcc_pkg::VIS_BITS-1:0] vis_im,
  output logic                              last_of_dump
);

  logic [dbcc_pkg::NUM_ACC-1:0][dbcc_pkg::ACC_BITS-1:0] q_data [2];
  logic [1:0]                    q_count;
  logic                          q_wr;
  logic                          q_rd;
  logic [dbcc_pkg::SEL_BITS-1:0] sel;
  logic                          load;
  logic                          pop;

  assign q_full = (q_count == 2'd2);

  // Move one result into the output register whenever it is empty or being taken.
  assign load = (q_count != 2'd0) && (!out_valid || !out_stall);
  assign pop  = load && (sel == dbcc_pkg::SEL_LAST);

  // Queue pointers, result selector and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count   <= '0;
      q_wr      <= 1'b0;
      q_rd      <= 1'b0;
      sel       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push.valid) begin
        q_wr <= ~q_wr;
      end
      if (pop) begin
        q_rd <= ~q_rd;
      end
      q_count <= q_count + {1'b0, push.valid} - {1'b0, pop};
      if (load) begin
        sel       <= sel + dbcc_pkg::SEL_BITS'(1);
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Queue storage and output payload.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_data[q_wr] <= push.acc;
    end
    if (load) begin
      which_baseline <= sel[dbcc_pkg::SEL_BITS-1];
      pol_product    <= sel[1:0];
      vis_re         <= dbcc_pkg::vis_value(q_data[q_rd][{sel, 1'b0}]);
      vis_im         <= dbcc_pkg::vis_value(q_data[q_rd][{sel, 1'b1}]);
      last_of_dump   <= (sel == dbcc_pkg::SEL_LAST);
    end
  end

endmodule

/* rtl/core/dual_baseline_cross_correlator_unit.sv */
// Dual-baseline cross-correlator cell: correlates stations A and B against a
// reference station C in both polarizations, giving eight visibilities.
// Input channel (in_valid / in_stall): one time step per transaction, twelve
// 16-bit signed samples. A transaction is taken every cycle unless a finished
// dump finds the two-entry result queue full.
// Configuration (cfg_we / cfg_wdata): nr_times, the time steps per dump.
// Output channel (out_valid / out_stall): after nr_times steps the cell emits
// eight transactions, baseline A xx, xy, yx, yy then baseline B likewise, the
// last flagged by last_of_dump. Accumulators restart from zero.
// The closing step passes the product register, the result queue and the
// output register before the first result of its dump appears. Throughput
// is one step per cycle while nr_times is at least eight and the receiver
// does not stall; otherwise the drain of each dump through the output
// register sets the rate.
// When the receiver stalls, results wait in the output register and queue,
// and the input stalls only once a further dump finds the queue full.
// Reset clears the accumulators and step counter, empties the queue and sets
// nr_times to 256.
module dual_baseline_cross_correlator_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [15:0]                          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [15:0]                   a_x_re,
  input  logic signed [15:0]                   a_x_im,
  input  logic signed [15:0]                   a_y_re,
  input  logic signed [15:0]                   a_y_im,
  input  logic signed [15:0]                   b_x_re,
  input  logic signed [15:0]                   b_x_im,
  input  logic signed [15:0]                   b_y_re,
  input  logic signed [15:0]                   b_y_im,
  input  logic signed [15:0]                   c_x_re,
  input  logic signed [15:0]                   c_x_im,
  input  logic signed [15:0]                   c_y_re,
  input  logic signed [15:0]                   c_y_im,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 which_baseline,
  output logic [1:0]                           pol_product,
  output logic signed [47:0]                   vis_re,
  output logic signed [47:0]                   vis_im,
  output logic                                 last_of_dump
);

  dbcc_pkg::in_item_t item;
  dbcc_pkg::prod_t    prod;
  dbcc_pkg::push_t    push;
  logic               take;
  logic               q_full;

  // Gather the input fields into one transaction.
  assign item = '{a_x_re: a_x_re, a_x_im: a_x_im, a_y_re: a_y_re, a_y_im: a_y_im,
                  b_x_re: b_x_re, b_x_im: b_x_im, b_y_re: b_y_re, b_y_im: b_y_im,
                  c_x_re: c_x_re, c_x_im: c_x_im, c_y_re: c_y_re, c_y_im: c_y_im};

  // Front end: step counting and multipliers.
  dbcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .prod      (prod)
  );

  // Accumulators.
  dbcc_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .prod   (prod),
    .q_full (q_full),
    .take   (take),
    .push   (push)
  );

  // Back end: result queue and serializer.
  dbcc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .q_full         (q_full),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .which_baseline (which_baseline),
    .pol_product    (pol_product),
    .vis_re         (vis_re),
    .vis_im         (vis_im),
    .last_of_dump   (last_of_dump)
  );

  // A dump is never pushed into a full queue.
  assert property (@(posedge clk) disable iff (rst) push.valid |-> !q_full)
    else $error("dump pushed into a full result queue");

  // The input stalls only while a closing step waits for queue space.
  assert property (@(posedge clk) disable iff (rst)
                   in_stall |-> (prod.valid && prod.dump && q_full))
    else $error("input stalled without a blocked dump");

  // The flagged result is always baseline B, polarization pair yy.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && last_of_dump) |-> (which_baseline && pol_product == 2'd3))
    else $error("last_of_dump on the wrong result");

  // Nothing is offered on the output right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
